[rtl/plm_pkg.sv]
package plm_pkg;

  localparam int CAPACITY = 128;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int CMD_W    = 2;
  localparam int COUNT_W  = 8;

  // cell index and fill count widths
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // scratch width for position / fill compares
  localparam int WIDE_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 2;

  // read gather: cells are OR-ed in groups, groups registered
  localparam int GRP_SIZE = 8;
  localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_WRITE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_REDUCE
  } state_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic              ins_en;
    logic              del_en;
    logic              wr_en;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] wval;
    logic [IDX_W-1:0]  rd_idx;
  } cell_ctl_t;

endpackage

[rtl/plm_if.sv]
interface plm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [plm_pkg::CMD_W-1:0]             cmd;
  logic [plm_pkg::POS_W-1:0]             pos;
  logic signed [plm_pkg::DATA_W-1:0]     write_value;

  modport source (output valid, cmd, pos, write_value, input ready);
  modport sink   (input valid, cmd, pos, write_value, output ready);
endinterface

interface plm_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  ok;
  logic signed [plm_pkg::DATA_W-1:0]     read_value;
  logic [plm_pkg::COUNT_W-1:0]           count;

  modport source (output valid, ok, read_value, count, input ready);
  modport sink   (input valid, ok, read_value, count, output ready);
endinterface

[rtl/plm_cell.sv]
module plm_cell (
  input  logic                          clk,
  input  plm_pkg::cell_ctl_t            ctl,
  input  logic [plm_pkg::IDX_W-1:0]     my_idx,
  input  logic [plm_pkg::DATA_W-1:0]    left_val,
  input  logic [plm_pkg::DATA_W-1:0]    right_val,
  output logic [plm_pkg::DATA_W-1:0]    val,
  output logic [plm_pkg::DATA_W-1:0]    rd_val
);

  logic [plm_pkg::DATA_W-1:0] val_r;
  logic [plm_pkg::DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins_en) begin
      if (my_idx > ctl.idx) begin
        val_nxt = left_val;
      end else if (my_idx == ctl.idx) begin
        val_nxt = ctl.wval;
      end
    end else if (ctl.del_en) begin
      if (my_idx >= ctl.idx) begin
        val_nxt = right_val;
      end
    end else if (ctl.wr_en) begin
      if (my_idx == ctl.idx) begin
        val_nxt = ctl.wval;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val    = val_r;
  assign rd_val = (my_idx == ctl.rd_idx) ? val_r : '0;

endmodule

[rtl/plm_cell_row.sv]
module plm_cell_row (
  input  logic                          clk,
  input  plm_pkg::cell_ctl_t            ctl,
  input  logic                          grp_ld,
  output logic [plm_pkg::DATA_W-1:0]    grp_r [plm_pkg::NGRP]
);

  logic [plm_pkg::DATA_W-1:0] val    [plm_pkg::CAPACITY];
  logic [plm_pkg::DATA_W-1:0] rd_val [plm_pkg::CAPACITY];
  logic [plm_pkg::DATA_W-1:0] grp_nxt [plm_pkg::NGRP];

  for (genvar i = 0; i < plm_pkg::CAPACITY; i++) begin : g_cell
    logic [plm_pkg::DATA_W-1:0] left_v;
    logic [plm_pkg::DATA_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_left
      assign left_v = val[i-1];
    end

    if (i == plm_pkg::CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_right
      assign right_v = val[i+1];
    end

    plm_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .my_idx    (plm_pkg::IDX_W'(i)),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (val[i]),
      .rd_val    (rd_val[i])
    );
  end

  // only the selected cell drives nonzero, so OR acts as the mux
  always_comb begin
    for (int g = 0; g < plm_pkg::NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < plm_pkg::GRP_SIZE; k++) begin
        if (g * plm_pkg::GRP_SIZE + k < plm_pkg::CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | rd_val[g * plm_pkg::GRP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_ld) begin
      grp_r <= grp_nxt;
    end
  end

endmodule

[rtl/positional_list_engine_top.sv]
// Positional list engine: ordered list of signed 32-bit words in a row of cells.
// Requests are accepted only in S_IDLE; none is taken until the last result
//   is loaded. Each passes the two-stage registered read gather (group OR in
//   S_GATHER, then final OR in S_REDUCE, which waits for a free output reg).
// Reset: synchronous active-low rst_n empties the list (fill = 0); cell
//   contents are not cleared and are only read after being written.
module positional_list_engine_top (
  input  logic         clk,
  input  logic         rst_n,
  plm_in_if.sink       in_ch,
  plm_out_if.source    out_ch
);

  localparam int WW = plm_pkg::WIDE_W;

  plm_pkg::state_t   state_r, state_nxt;
  plm_pkg::cell_ctl_t ctl;

  logic [plm_pkg::CNT_W-1:0]  fill_r, fill_nxt;
  logic [plm_pkg::IDX_W-1:0]  idx_r;
  logic                       rd_r;     // pending request is a read
  logic                       ok_r;     // pending request was carried out

  logic                       out_valid_r;
  logic                       out_ok_r;
  logic [plm_pkg::DATA_W-1:0] out_rval_r;
  logic [plm_pkg::COUNT_W-1:0] out_cnt_r;

  logic                       accept;
  logic                       grp_ld;
  logic                       out_load;
  logic                       req_ok;
  logic                       pos_nz;
  plm_pkg::cmd_t              cmd;
  logic [WW-1:0]              pos_w;
  logic [WW-1:0]              fill_w;
  logic [WW-1:0]              fill_next_w;
  logic [plm_pkg::IDX_W-1:0]  idx;
  logic [plm_pkg::DATA_W-1:0] grp_r [plm_pkg::NGRP];
  logic [plm_pkg::DATA_W-1:0] gather;

  // ---------------------------------------------------------------
  // Request decode and range checks against the current fill
  // ---------------------------------------------------------------
  assign accept = in_ch.valid && in_ch.ready;
  assign cmd    = plm_pkg::cmd_t'(in_ch.cmd);
  assign pos_w  = WW'(in_ch.pos);
  assign fill_w = WW'(fill_r);
  assign pos_nz = (in_ch.pos != '0);
  assign idx    = plm_pkg::IDX_W'(pos_w - WW'(1));

  always_comb begin
    case (cmd)
      plm_pkg::CMD_INSERT:
        req_ok = pos_nz && (pos_w <= fill_w + WW'(1)) &&
                 (fill_w < WW'(plm_pkg::CAPACITY));
      default:
        req_ok = pos_nz && (pos_w <= fill_w);
    endcase
  end

  // Cell control: shifts and writes happen at the accept edge
  always_comb begin
    ctl.ins_en = accept && req_ok && (cmd == plm_pkg::CMD_INSERT);
    ctl.del_en = accept && req_ok && (cmd == plm_pkg::CMD_DELETE);
    ctl.wr_en  = accept && req_ok && (cmd == plm_pkg::CMD_WRITE);
    ctl.idx    = idx;
    ctl.wval   = in_ch.write_value;
    ctl.rd_idx = idx_r;
  end

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.ins_en) begin
      fill_nxt = fill_r + plm_pkg::CNT_W'(1);
    end else if (ctl.del_en) begin
      fill_nxt = fill_r - plm_pkg::CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------
  // Cell row with registered group gather
  // ---------------------------------------------------------------
  plm_cell_row u_row (
    .clk    (clk),
    .ctl    (ctl),
    .grp_ld (grp_ld),
    .grp_r  (grp_r)
  );

  // final OR over the registered groups
  always_comb begin
    gather = '0;
    for (int g = 0; g < plm_pkg::NGRP; g++) begin
      gather = gather | grp_r[g];
    end
  end

  // ---------------------------------------------------------------
  // Sequencer: idle -> gather groups -> reduce and hand to output reg
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    grp_ld      = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      plm_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = plm_pkg::S_GATHER;
        end
      end
      plm_pkg::S_GATHER: begin
        grp_ld    = 1'b1;
        state_nxt = plm_pkg::S_REDUCE;
      end
      plm_pkg::S_REDUCE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = plm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = plm_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pending request and result payload
  assign fill_next_w = WW'(fill_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= idx;
      rd_r  <= (cmd == plm_pkg::CMD_READ);
      ok_r  <= req_ok;
    end
    if (out_load) begin
      out_ok_r   <= ok_r;
      out_rval_r <= (rd_r && ok_r) ? gather : '0;
      out_cnt_r  <= fill_next_w[plm_pkg::COUNT_W-1:0];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = out_ok_r;
  assign out_ch.read_value = out_rval_r;
  assign out_ch.count      = out_cnt_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_w <= WW'(plm_pkg::CAPACITY))
    else $error("fill exceeds capacity");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> fill_r == $past(fill_r) + plm_pkg::CNT_W'(1))
    else $error("insert did not grow the list");

  a_del_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.del_en |=> fill_r == $past(fill_r) - plm_pkg::CNT_W'(1))
    else $error("delete did not shrink the list");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> out_rval_r == '0)
    else $error("rejected request returned nonzero data");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != plm_pkg::S_IDLE) |-> !accept)
    else $error("request accepted while busy");
`endif

endmodule

[tb/sv/tb_positional_list_engine_top.sv]
`timescale 1ns / 1ps

module tb_positional_list_engine_top;

  // One request as the stimulus table and the random generator see it. When
  // has_exp is set, the response fields below are the literal expectation;
  // otherwise the shadow list decides what comes back.
  typedef struct {
    plm_pkg::cmd_t                     cmd;
    logic [plm_pkg::POS_W-1:0]         pos;
    logic signed [plm_pkg::DATA_W-1:0] wval;
    bit                                has_exp;
    logic                              ok;
    logic signed [plm_pkg::DATA_W-1:0] rval;
    logic [plm_pkg::COUNT_W-1:0]       cnt;
  } req_row_t;

  typedef struct {
    logic                              ok;
    logic signed [plm_pkg::DATA_W-1:0] read_value;
    logic [plm_pkg::COUNT_W-1:0]       count;
  } resp_t;

  // Command mixes for the random part: grow fills the list up to full,
  // shrink drains it, balanced sits in between.
  typedef enum {MIX_GROW, MIX_BALANCED, MIX_SHRINK} mix_t;

  localparam int N_DIRECTED = 22;
  localparam int GROW_LEN   = 180;
  localparam int BAL_LEN    = 60;
  localparam int SHRINK_LEN = 50;

  logic clk;
  logic rst_n;

  plm_in_if  in_ch ();
  plm_out_if out_ch ();

  positional_list_engine_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the list: entries in order plus the fill count.
  logic signed [plm_pkg::DATA_W-1:0] shadow_list [plm_pkg::CAPACITY];
  int                                shadow_len = 0;

  // Responses owed by the DUT, oldest first.
  resp_t    pending_resp [$];
  req_row_t cur_req;
  req_row_t directed_rows [N_DIRECTED];

  int err_cnt        = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Applies one request to the shadow list and returns the response it owes.
  // Rejected requests (bad position, insert into a full list) leave the list
  // untouched and answer with ok low, zero data and the current fill.
  function automatic resp_t apply_list_op(plm_pkg::cmd_t op,
                                          logic [plm_pkg::POS_W-1:0] pos,
                                          logic signed [plm_pkg::DATA_W-1:0] wv);
    resp_t r;
    int    p;
    int    idx;
    r.ok         = 1'b0;
    r.read_value = '0;
    p            = int'(pos);
    if (op == plm_pkg::CMD_INSERT) begin
      if (p >= 1 && p <= shadow_len + 1 && shadow_len < plm_pkg::CAPACITY) begin
        for (idx = shadow_len; idx > p - 1; idx--)
          shadow_list[idx] = shadow_list[idx-1];
        shadow_list[p-1] = wv;
        shadow_len++;
        r.ok = 1'b1;
      end
    end else if (p >= 1 && p <= shadow_len) begin
      case (op)
        plm_pkg::CMD_DELETE: begin
          for (idx = p - 1; idx + 1 < shadow_len; idx++)
            shadow_list[idx] = shadow_list[idx+1];
          shadow_len--;
        end
        plm_pkg::CMD_READ: begin
          r.read_value = shadow_list[p-1];
        end
        default: begin
          shadow_list[p-1] = wv;
        end
      endcase
      r.ok = 1'b1;
    end
    r.count = plm_pkg::COUNT_W'(shadow_len);
    return r;
  endfunction

  // Random request. Most positions are legal for the current fill; the rest
  // hit the edges (zero, last legal, one past) or land anywhere in 0..255.
  function automatic req_row_t make_req(mix_t mix);
    req_row_t r;
    int       roll;
    int       lim;
    int       pick;
    roll = $urandom_range(99);
    case (mix)
      MIX_GROW: begin
        if (roll < 95)      r.cmd = plm_pkg::CMD_INSERT;
        else if (roll < 97) r.cmd = plm_pkg::CMD_DELETE;
        else if (roll < 99) r.cmd = plm_pkg::CMD_READ;
        else                r.cmd = plm_pkg::CMD_WRITE;
      end
      MIX_SHRINK: begin
        if (roll < 10)      r.cmd = plm_pkg::CMD_INSERT;
        else if (roll < 80) r.cmd = plm_pkg::CMD_DELETE;
        else if (roll < 90) r.cmd = plm_pkg::CMD_READ;
        else                r.cmd = plm_pkg::CMD_WRITE;
      end
      default: begin
        if (roll < 30)      r.cmd = plm_pkg::CMD_INSERT;
        else if (roll < 55) r.cmd = plm_pkg::CMD_DELETE;
        else if (roll < 80) r.cmd = plm_pkg::CMD_READ;
        else                r.cmd = plm_pkg::CMD_WRITE;
      end
    endcase

    lim  = (r.cmd == plm_pkg::CMD_INSERT) ? shadow_len + 1 : shadow_len;
    roll = $urandom_range(99);
    if (roll < 82) begin
      r.pos = (lim == 0) ? plm_pkg::POS_W'(1) :
                           plm_pkg::POS_W'($urandom_range(lim, 1));
    end else if (roll < 92) begin
      pick  = $urandom_range(2);
      r.pos = (pick == 0) ? '0 : plm_pkg::POS_W'(lim + pick - 1);
    end else begin
      r.pos = plm_pkg::POS_W'($urandom_range(255));
    end

    if ($urandom_range(99) < 10) begin
      case ($urandom_range(3))
        0:       r.wval = 32'sh8000_0000;
        1:       r.wval = 32'sh7fff_ffff;
        2:       r.wval = '0;
        default: r.wval = -32'sd1;
      endcase
    end else begin
      r.wval = $urandom;
    end

    r.has_exp = 1'b0;
    r.ok      = 1'b0;
    r.rval    = '0;
    r.cnt     = '0;
    return r;
  endfunction

  // Presents one request from a falling edge, after a random sender gap, and
  // returns on the falling edge after it was taken. valid stays high while
  // the DUT holds ready low.
  task automatic send_req(input req_row_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= r.cmd;
    in_ch.pos         <= r.pos;
    in_ch.write_value <= r.wval;
    cur_req           <= r;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Result side: ready moves on the falling edge, stalling at the phase rate.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Scoreboard, sampled on the rising edge. An accepted request pushes its
  // expected response; an accepted response is checked against the oldest one.
  always @(posedge clk) begin
    resp_t pred;
    resp_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        // shadow state always advances, even on rows with literal expectations
        pred = apply_list_op(plm_pkg::cmd_t'(in_ch.cmd), in_ch.pos,
                             in_ch.write_value);
        if (cur_req.has_exp) begin
          pred.ok         = cur_req.ok;
          pred.read_value = cur_req.rval;
          pred.count      = cur_req.cnt;
        end
        pending_resp.push_back(pred);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_resp.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected response ok=%0b rd=%0d cnt=%0d", $realtime,
                     out_ch.ok, out_ch.read_value, out_ch.count);
        end else begin
          want = pending_resp.pop_front();
          if (out_ch.ok !== want.ok || out_ch.read_value !== want.read_value ||
              out_ch.count !== want.count) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch exp ok=%0b rd=%0d cnt=%0d, got ok=%0b rd=%0d cnt=%0d",
                       $realtime, want.ok, want.read_value, want.count,
                       out_ch.ok, out_ch.read_value, out_ch.count);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int   ph;
    int   n;
    mix_t mix;

    // Directed requests, starting from the empty list after reset.
    // Columns: cmd, pos, write value, literal?, ok, read value, count.
    directed_rows = '{
      // empty list: nothing addressable, insert only at position one
      '{plm_pkg::CMD_READ,   8'd1,   32'sd0,         1'b1, 1'b0, 32'sd0,         8'd0},
      '{plm_pkg::CMD_DELETE, 8'd1,   32'sd0,         1'b1, 1'b0, 32'sd0,         8'd0},
      '{plm_pkg::CMD_WRITE,  8'd1,   32'sd7,         1'b1, 1'b0, 32'sd0,         8'd0},
      '{plm_pkg::CMD_INSERT, 8'd0,   32'sd5,         1'b1, 1'b0, 32'sd0,         8'd0},
      '{plm_pkg::CMD_INSERT, 8'd2,   32'sd5,         1'b1, 1'b0, 32'sd0,         8'd0},
      // build [0, min, max]: append, then insert at the head
      '{plm_pkg::CMD_INSERT, 8'd1,   32'sh8000_0000, 1'b1, 1'b1, 32'sd0,         8'd1},
      '{plm_pkg::CMD_INSERT, 8'd2,   32'sh7fff_ffff, 1'b1, 1'b1, 32'sd0,         8'd2},
      '{plm_pkg::CMD_INSERT, 8'd1,   32'sd0,         1'b1, 1'b1, 32'sd0,         8'd3},
      '{plm_pkg::CMD_READ,   8'd1,   32'sh5a5a_5a5a, 1'b1, 1'b1, 32'sd0,         8'd3},
      '{plm_pkg::CMD_READ,   8'd2,   32'sd0,         1'b1, 1'b1, 32'sh8000_0000, 8'd3},
      '{plm_pkg::CMD_READ,   8'd3,   32'sd0,         1'b1, 1'b1, 32'sh7fff_ffff, 8'd3},
      // past the end, top of the position range, position zero
      '{plm_pkg::CMD_READ,   8'd4,   32'sd0,         1'b1, 1'b0, 32'sd0,         8'd3},
      '{plm_pkg::CMD_READ,   8'd255, 32'sd0,         1'b1, 1'b0, 32'sd0,         8'd3},
      '{plm_pkg::CMD_READ,   8'd0,   32'sd0,         1'b1, 1'b0, 32'sd0,         8'd3},
      '{plm_pkg::CMD_WRITE,  8'd4,   -32'sd1,        1'b1, 1'b0, 32'sd0,         8'd3},
      '{plm_pkg::CMD_WRITE,  8'd2,   -32'sd1,        1'b1, 1'b1, 32'sd0,         8'd3},
      '{plm_pkg::CMD_INSERT, 8'd5,   32'sh1234_5678, 1'b1, 1'b0, 32'sd0,         8'd3},
      // shifting cases go through the shadow list
      '{plm_pkg::CMD_INSERT, 8'd4,   32'sh1234_5678, 1'b0, 1'b0, 32'sd0,         8'd0},
      '{plm_pkg::CMD_DELETE, 8'd5,   32'shffff_ffff, 1'b1, 1'b0, 32'sd0,         8'd4},
      '{plm_pkg::CMD_DELETE, 8'd2,   32'sh0f0f_0f0f, 1'b0, 1'b0, 32'sd0,         8'd0},
      '{plm_pkg::CMD_READ,   8'd2,   32'shf0f0_f0f0, 1'b0, 1'b0, 32'sd0,         8'd0},
      '{plm_pkg::CMD_INSERT, 8'd255, 32'sh0000_0001, 1'b1, 1'b0, 32'sd0,         8'd3}
    };

    // drive every input before the first edge
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = plm_pkg::CMD_READ;
    in_ch.pos         = '0;
    in_ch.write_value = '0;
    out_ch.ready      = 1'b0;
    cur_req           = directed_rows[0];

    // single reset, released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_req(directed_rows[i]);

    // Random part in four pressure phases: none, sender sparse, receiver
    // stalling, both moderate. Each phase grows to full, mixes, then drains.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 81; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 81; end
        default: begin src_idle_pct = 22; sink_stall_pct = 22; end
      endcase
      for (n = 0; n < GROW_LEN + BAL_LEN + SHRINK_LEN; n++) begin
        if (n < GROW_LEN)                mix = MIX_GROW;
        else if (n < GROW_LEN + BAL_LEN) mix = MIX_BALANCED;
        else                             mix = MIX_SHRINK;
        send_req(make_req(mix));
      end
    end

    in_ch.valid <= 1'b0;

    // drain the pipe, then wait for anything stray
    while (pending_resp.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (err_cnt == 0 && pending_resp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/plm_pkg.sv
rtl/plm_if.sv
rtl/plm_cell.sv
rtl/plm_cell_row.sv
rtl/positional_list_engine_top.sv
tb/sv/tb_positional_list_engine_top.sv
